@@ hdl/gear_hash_cut_scanner_assert.svh @@
// assertion macros for the gear hash cut scanner
// used by the top level, relies on signals clk and rst in the including scope
`ifndef GEAR_HASH_CUT_SCANNER_ASSERT_SVH
`define GEAR_HASH_CUT_SCANNER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// antecedent implies consequent in the same cycle
`define GHCS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gear hash cut scanner: check failed");

// antecedent implies consequent in the next cycle
`define GHCS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gear hash cut scanner: check failed");

// condition never holds
`define GHCS_ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("gear hash cut scanner: check failed");

`else

`define GHCS_ASSERT_IMPL(label, ante, cons)
`define GHCS_ASSERT_NEXT(label, ante, cons)
`define GHCS_ASSERT_NEVER(label, cond)

`endif

`endif

@@ hdl/ghcs_pkg.sv @@
// shared types and constants of the gear hash cut scanner
// no dependencies; used by the table ram, the result fifo and the top level
package ghcs_pkg;

  localparam int HASH_W        = 64;
  localparam int BYTE_W        = 8;
  localparam int TABLE_DEPTH   = 256;
  localparam int INDEX_W       = 8;
  localparam int COUNT_W       = 4;
  localparam int LANE_W        = 3;
  localparam int MAX_LANES     = 8;
  localparam int LANES_DEFAULT = 8;

  typedef enum logic [1:0] {
    CMD_SCAN = 2'd0,
    CMD_LOAD = 2'd1,
    CMD_SEED = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_t;

  // one result transaction, packed in the order of the output bus (lsb last)
  typedef struct packed {
    logic [HASH_W-1:0]    hash_at_cut;
    logic [MAX_LANES-1:0] cut_lanes;
    logic [LANE_W-1:0]    first_cut_lane;
    logic                 cut_found;
  } result_t;

endpackage

@@ hdl/ghcs_table_ram.sv @@
// one copy of the 256 x 64 gear table, one write and one registered read port
// depends on ghcs_pkg
module ghcs_table_ram (
  input  logic                                clk,
  input  logic                                wr_en,
  input  logic [ghcs_pkg::INDEX_W-1:0]        wr_addr,
  input  logic [ghcs_pkg::HASH_W-1:0]         wr_data,
  input  logic [ghcs_pkg::INDEX_W-1:0]        rd_addr,
  output logic [ghcs_pkg::HASH_W-1:0]         rd_data
);

  logic [ghcs_pkg::HASH_W-1:0] mem [ghcs_pkg::TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

@@ hdl/ghcs_out_fifo.sv @@
// small result fifo that parts the pipeline from the output stream
// depends on ghcs_pkg for the result type
module ghcs_out_fifo #(
  parameter int DEPTH = 6
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  ghcs_pkg::result_t  push_data,
  output logic               pop_valid,
  input  logic               pop_ready,
  output ghcs_pkg::result_t  pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ghcs_pkg::result_t mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              pop;

  assign pop_valid = (count != '0);
  assign pop_data  = mem[rd_ptr];
  assign pop       = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

endmodule

@@ hdl/gear_hash_cut_scanner.sv @@
// top level of the gear hash cut scanner: stream ports, table copies,
// prefix stages, hash stage and result fifo
// depends on ghcs_pkg, ghcs_table_ram, ghcs_out_fifo, gear_hash_cut_scanner_assert.svh

// Content-defined chunking cut finder on a Gear rolling hash
// (hash = (hash << 1) + table[byte], mod 2^64; a byte is a cut when hash & cut_mask is zero).
// Each input transaction carries a command in s_tuser: scan up to eight bytes, load one
// table word, or seed the hash; every command returns exactly one result transaction, in
// order. The block takes one transaction per clock while s_tready is high, and each one
// passes the registered table read, the prefix levels and the hash stage on its way to the
// output fifo. That rate is set by the table: every lane has its own copy of the 256-word
// table, all written together by a load, each read once per cycle with a registered read.
// The per-byte chain of adds is broken into a registered prefix tree over the table words,
// so the only add on the hash feedback loop is one 64-bit add per lane. A load takes effect
// for any scan that follows it. Table words are undefined after reset and must be loaded
// before they are used; there is no clearing pass. The user must see that cut_mask is written
// through cfg_wr_en / cfg_wr_data only while the block is idle; the block does not enforce
// this. s_tready drops only when the result fifo, counting the transactions still in the pipeline, would be full.
`include "gear_hash_cut_scanner_assert.svh"

module gear_hash_cut_scanner #(
  parameter int LANES = ghcs_pkg::LANES_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  // input stream
  input  logic         s_tvalid,
  output logic         s_tready,
  // tdata, lsb up: data_block[63:0], byte_count[67:64], table_index[75:68],
  // load_value[139:76], zero pad[143:140]
  input  logic [143:0] s_tdata,
  // tuser: cmd[1:0]
  input  logic [1:0]   s_tuser,
  // result stream
  output logic         m_tvalid,
  input  logic         m_tready,
  // tdata, lsb up: cut_found[0], first_cut_lane[3:1], cut_lanes[11:4],
  // hash_at_cut[75:12], zero pad[79:76]
  output logic [79:0]  m_tdata,
  // cut mask register
  input  logic         cfg_wr_en,
  input  logic [63:0]  cfg_wr_data
);

  localparam int HW    = ghcs_pkg::HASH_W;
  localparam int BW    = ghcs_pkg::BYTE_W;
  localparam int CW    = ghcs_pkg::COUNT_W;
  localparam int LW    = ghcs_pkg::LANE_W;
  localparam int ML    = ghcs_pkg::MAX_LANES;
  // lanes actually used: the data word holds eight bytes
  localparam int NL    = (LANES < ghcs_pkg::MAX_LANES) ? LANES : ghcs_pkg::MAX_LANES;
  localparam int LVLS  = $clog2(NL);
  // ram stage + prefix levels + hash stage, plus slack for full rate
  localparam int FDEPTH = LVLS + 4;
  localparam int CRW    = $clog2(FDEPTH + 1);

  // sideband that travels next to the table words
  typedef struct packed {
    ghcs_pkg::cmd_t cmd;
    logic [CW-1:0]  count;
    logic [HW-1:0]  seed;
  } side_t;

  // input field split
  logic [HW-1:0]                 in_data;
  logic [CW-1:0]                 in_count;
  logic [ghcs_pkg::INDEX_W-1:0]  in_index;
  logic [HW-1:0]                 in_value;
  ghcs_pkg::cmd_t                in_cmd;
  logic [CW-1:0]                 in_count_sat;

  assign in_data  = s_tdata[63:0];
  assign in_count = s_tdata[67:64];
  assign in_index = s_tdata[75:68];
  assign in_value = s_tdata[139:76];
  assign in_cmd   = ghcs_pkg::cmd_t'(s_tuser);
  // counts above the lane count saturate
  assign in_count_sat = (in_count > CW'(NL)) ? CW'(NL) : in_count;

  logic s_accept;
  logic m_accept;
  assign s_accept = s_tvalid && s_tready;
  assign m_accept = m_tvalid && m_tready;

  // configuration
  logic [HW-1:0] cut_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      cut_mask <= '0;
    end else if (cfg_wr_en) begin
      cut_mask <= cfg_wr_data;
    end
  end

  // credit count: transactions accepted and not yet taken from the fifo
  logic [CRW-1:0] credits;

  assign s_tready = (credits < CRW'(FDEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      credits <= '0;
    end else begin
      credits <= credits + CRW'(s_accept) - CRW'(m_accept);
    end
  end

  // table copies, one per lane; level 0 of the prefix tree is the raw table word
  logic [NL-1:0][HW-1:0] pref [LVLS+1];
  logic [LVLS:0]         vld;
  side_t                 side [LVLS+1];
  logic                  tbl_we;

  assign tbl_we = s_accept && (in_cmd == ghcs_pkg::CMD_LOAD);

  genvar gk, gi;
  for (gk = 0; gk < NL; gk++) begin : g_lane
    ghcs_table_ram u_table (
      .clk     (clk),
      .wr_en   (tbl_we),
      .wr_addr (in_index),
      .wr_data (in_value),
      .rd_addr (in_data[BW*gk +: BW]),
      .rd_data (pref[0][gk])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= s_accept;
    end
  end

  always_ff @(posedge clk) begin
    side[0].cmd   <= in_cmd;
    side[0].count <= in_count_sat;
    side[0].seed  <= in_value;
  end

  // prefix tree: lane k ends with sum of table words j <= k, each shifted by k - j
  for (gi = 0; gi < LVLS; gi++) begin : g_level
    localparam int SH = 1 << gi;

    always_ff @(posedge clk) begin
      for (int k = 0; k < NL; k++) begin
        if (k >= SH) begin
          pref[gi+1][k] <= (pref[gi][k-SH] << SH) + pref[gi][k];
        end else begin
          pref[gi+1][k] <= pref[gi][k];
        end
      end
      side[gi+1] <= side[gi];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[gi+1] <= 1'b0;
      end else begin
        vld[gi+1] <= vld[gi];
      end
    end
  end

  // hash stage: the only part on the feedback loop
  logic [HW-1:0]         hash;
  logic [HW-1:0]         hash_next;
  logic [NL-1:0][HW-1:0] lane_hash;
  logic [ML-1:0]         lanes;
  logic                  found;
  logic [LW-1:0]         first_lane;
  logic [HW-1:0]         hash_first;
  logic [HW-1:0]         hash_last;
  ghcs_pkg::result_t     res;
  side_t                 side_l;

  assign side_l = side[LVLS];

  always_comb begin
    lanes      = '0;
    first_lane = '0;
    hash_first = hash;
    hash_last  = hash;
    for (int k = 0; k < NL; k++) begin
      lane_hash[k] = (hash << (k + 1)) + pref[LVLS][k];
      // only bytes inside the count are tested
      lanes[k] = (CW'(k) < side_l.count) && ((lane_hash[k] & cut_mask) == '0);
      if (CW'(k + 1) == side_l.count) begin
        hash_last = lane_hash[k];
      end
    end
    // walk down so the lowest cut wins
    for (int k = NL - 1; k >= 0; k--) begin
      if (lanes[k]) begin
        first_lane = LW'(k);
        hash_first = lane_hash[k];
      end
    end
    found = (lanes != '0);

    res       = '0;
    hash_next = hash;
    case (side_l.cmd)
      ghcs_pkg::CMD_SCAN: begin
        res.cut_found      = found;
        res.first_cut_lane = first_lane;
        res.cut_lanes      = lanes;
        res.hash_at_cut    = found ? hash_first : hash_last;
        hash_next          = hash_last;
      end
      ghcs_pkg::CMD_SEED: begin
        res.hash_at_cut = side_l.seed;
        hash_next       = side_l.seed;
      end
      default: begin
        // load and no-op leave the hash alone
        res.hash_at_cut = hash;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hash <= '0;
    end else if (vld[LVLS]) begin
      hash <= hash_next;
    end
  end

  // output fifo
  ghcs_pkg::result_t out_q;

  ghcs_out_fifo #(
    .DEPTH (FDEPTH)
  ) u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (vld[LVLS]),
    .push_data (res),
    .pop_valid (m_tvalid),
    .pop_ready (m_tready),
    .pop_data  (out_q)
  );

  assign m_tdata = {4'b0000, out_q};

  // checks
  `GHCS_ASSERT_NEVER(a_credit_bound, credits > CRW'(FDEPTH))
  `GHCS_ASSERT_IMPL(a_push_has_credit, vld[LVLS], credits != '0)
  `GHCS_ASSERT_IMPL(a_out_has_credit, m_tvalid, credits != '0)
  `GHCS_ASSERT_IMPL(a_no_cut_off_scan, vld[LVLS] && (side_l.cmd != ghcs_pkg::CMD_SCAN),
                    !res.cut_found && (res.cut_lanes == '0) && (res.first_cut_lane == '0))
  `GHCS_ASSERT_NEXT(a_seed_loads_hash, vld[LVLS] && (side_l.cmd == ghcs_pkg::CMD_SEED),
                    hash == $past(side_l.seed))

endmodule

@@ tb/ghcs_tb_pkg.sv @@
`timescale 1ns / 1ps
// result tracking for the gear hash cut scanner testbench: a class that predicts
// each result from accepted transactions and checks results as they arrive; needs ghcs_pkg
package ghcs_tb_pkg;
  import ghcs_pkg::*;

  class cut_result_board;
    logic [HASH_W-1:0] cut_mask;
    logic [HASH_W-1:0] running_hash;
    logic [HASH_W-1:0] gear_words [TABLE_DEPTH];
    result_t           pending_cuts [$];
    int                mismatch_count;

    function new();
      cut_mask       = '0;
      running_hash   = '0;
      mismatch_count = 0;
      foreach (gear_words[i]) gear_words[i] = '0;
    endfunction

    function result_t next_cut_result(cmd_t cmd, logic [63:0] blk, logic [COUNT_W-1:0] cnt,
                                      logic [INDEX_W-1:0] idx, logic [HASH_W-1:0] val);
      result_t           r;
      logic [HASH_W-1:0] h;
      int                n;
      r = '0;
      h = running_hash;
      r.hash_at_cut = h;
      case (cmd)
        CMD_SCAN: begin
          // counts beyond the lane count saturate
          n = (cnt > MAX_LANES) ? MAX_LANES : cnt;
          for (int j = 0; j < n; j++) begin
            h = (h << 1) + gear_words[blk[8*j +: 8]];
            if ((h & cut_mask) == '0) begin
              r.cut_lanes[j] = 1'b1;
              if (!r.cut_found) begin
                r.cut_found      = 1'b1;
                r.first_cut_lane = LANE_W'(j);
                r.hash_at_cut    = h;
              end
            end
          end
          running_hash = h;
          if (!r.cut_found) r.hash_at_cut = h;
        end
        CMD_LOAD: gear_words[idx] = val;
        CMD_SEED: begin
          running_hash  = val;
          r.hash_at_cut = val;
        end
        default: ;
      endcase
      return r;
    endfunction

    function void note_transaction(cmd_t cmd, logic [63:0] blk, logic [COUNT_W-1:0] cnt,
                                   logic [INDEX_W-1:0] idx, logic [HASH_W-1:0] val);
      pending_cuts.push_back(next_cut_result(cmd, blk, cnt, idx, val));
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatch_count++;
    endtask

    task check_result(result_t got);
      result_t want;
      if (pending_cuts.size() == 0) begin
        report_mismatch($sformatf("result %h with none outstanding", got));
        return;
      end
      want = pending_cuts.pop_front();
      if (got.cut_found !== want.cut_found)
        report_mismatch($sformatf("cut_found %b, want %b", got.cut_found, want.cut_found));
      if (got.first_cut_lane !== want.first_cut_lane)
        report_mismatch($sformatf("first_cut_lane %0d, want %0d",
                                  got.first_cut_lane, want.first_cut_lane));
      if (got.cut_lanes !== want.cut_lanes)
        report_mismatch($sformatf("cut_lanes %b, want %b", got.cut_lanes, want.cut_lanes));
      if (got.hash_at_cut !== want.hash_at_cut)
        report_mismatch($sformatf("hash_at_cut %h, want %h",
                                  got.hash_at_cut, want.hash_at_cut));
    endtask
  endclass

endpackage

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// top of the gear hash cut scanner testbench: clock, reset, stream drivers and stimulus
// depends on ghcs_pkg, ghcs_tb_pkg and the gear_hash_cut_scanner rtl
module tb_top;
  import ghcs_pkg::*;
  import ghcs_tb_pkg::*;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  // tdata, lsb up: data_block, byte_count, table_index, load_value, zero pad
  logic [143:0] s_tdata = '0;
  // tuser: cmd
  logic [1:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  // tdata, lsb up: cut_found, first_cut_lane, cut_lanes, hash_at_cut, zero pad
  logic [79:0]  m_tdata;
  logic         cfg_wr_en = 1'b0;
  logic [63:0]  cfg_wr_data = '0;

  cut_result_board board;

  // idling percentages for the sender and the receiver side
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;

  // table entries loaded so far; scans only ever use these byte values
  logic [7:0] loaded_bytes [$];
  bit         byte_loaded [256];

  gear_hash_cut_scanner DUT (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #10 clk = ~clk;

  // receiver back-pressure, changed on the falling edge
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // every result transaction goes straight to the scoreboard
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_result(result_t'(m_tdata[75:0]));
  end

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // eight bytes drawn from the loaded table entries only
  function automatic logic [63:0] loaded_block();
    logic [63:0] blk;
    for (int j = 0; j < 8; j++)
      blk[8*j +: 8] = loaded_bytes[$urandom_range(loaded_bytes.size() - 1)];
    return blk;
  endfunction

  // a few scattered mask bits, so cuts stay neither certain nor rare
  function automatic logic [63:0] sparse_mask();
    logic [63:0] m;
    m = '0;
    repeat ($urandom_range(4, 2)) m[$urandom_range(63)] = 1'b1;
    return m;
  endfunction

  // present one transaction and hold it until the handshake completes
  task automatic send_transaction(cmd_t cmd, logic [63:0] blk, logic [3:0] cnt,
                                  logic [7:0] idx, logic [63:0] val);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {4'b0, val, idx, cnt, blk};
    do @(posedge clk); while (!s_tready);
    board.note_transaction(cmd, blk, cnt, idx, val);
    if (cmd == CMD_LOAD && !byte_loaded[idx]) begin
      byte_loaded[idx] = 1'b1;
      loaded_bytes.push_back(idx);
    end
  endtask

  task automatic scan(logic [63:0] blk, logic [3:0] cnt);
    send_transaction(CMD_SCAN, blk, cnt, 8'($urandom), rand_word());
  endtask

  task automatic load_word(logic [7:0] idx, logic [63:0] val);
    send_transaction(CMD_LOAD, rand_word(), 4'($urandom), idx, val);
  endtask

  task automatic seed_hash(logic [63:0] val);
    send_transaction(CMD_SEED, rand_word(), 4'($urandom), 8'($urandom), val);
  endtask

  // stop sending and wait for every outstanding result
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (board.pending_cuts.size() != 0) @(posedge clk);
  endtask

  // the mask only changes with the pipeline empty
  task automatic write_mask(logic [63:0] mask);
    drain();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mask;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    board.cut_mask = mask;
  endtask

  task automatic directed_checks();
    write_mask('1);
    load_word(8'h00, '0);
    load_word(8'hFF, '1);
    load_word(8'h5A, rand_word());
    load_word(8'hA5, rand_word());
    // hash stays zero on zero words, so with the full mask every lane cuts
    scan(64'h0, 4'd8);
    seed_hash('1);
    scan('1, 4'd8);
    // empty block, oversized count, single byte
    scan(64'h00FF_5AA5_FF00_A55A, 4'd0);
    scan(64'h00FF_5AA5_FF00_A55A, 4'd15);
    scan(64'h00FF_5AA5_FF00_A55A, 4'd1);
    send_transaction(CMD_NOP, rand_word(), 4'($urandom), 8'($urandom), rand_word());
    seed_hash('0);
    scan(64'hFF00_FF00_FF00_FF00, 4'd8);
    // empty mask: every valid byte is a cut
    write_mask('0);
    scan(loaded_block(), 4'd8);
    scan(loaded_block(), 4'd3);
    // overwrite a word that is already in use
    load_word(8'h5A, rand_word());
    scan(64'h5A5A_5A5A_5A5A_5A5A, 4'd8);
    seed_hash(rand_word());
    write_mask(64'h8000_0000_0000_0000);
    scan(loaded_block(), 4'd8);
  endtask

  // mostly full scans, with loads, seeds and the odd no-op mixed in
  task automatic random_transaction();
    int         pick;
    int         sel;
    logic [3:0] cnt;
    pick = $urandom_range(99);
    if (pick < 70) begin
      sel = $urandom_range(99);
      if (sel < 75)      cnt = 4'd8;
      else if (sel < 90) cnt = 4'($urandom_range(7, 1));
      else if (sel < 95) cnt = 4'd0;
      else               cnt = 4'($urandom_range(15, 9));
      scan(loaded_block(), cnt);
    end else if (pick < 84) begin
      sel = $urandom_range(9);
      load_word(8'($urandom), (sel == 0) ? '0 : (sel == 1) ? '1 : rand_word());
    end else if (pick < 96) begin
      seed_hash(($urandom_range(9) == 0) ? '0 : rand_word());
    end else begin
      send_transaction(CMD_NOP, rand_word(), 4'($urandom), 8'($urandom), rand_word());
    end
  endtask

  function automatic logic [63:0] segment_mask(int seg);
    case (seg)
      0:       return 64'h7;
      1:       return sparse_mask();
      2:       return 64'h8000_0000_0000_0000;
      3:       return 64'h1F;
      4:       return '0;
      default: return sparse_mask();
    endcase
  endfunction

  initial begin
    board = new();
    tx_idle_pct = 22;
    rx_idle_pct = 60;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    directed_checks();
    // six random segments, idling swapped after two and switched off after four
    for (int seg = 0; seg < 6; seg++) begin
      if (seg == 2) begin
        tx_idle_pct = 60;
        rx_idle_pct = 22;
      end else if (seg == 4) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      write_mask(segment_mask(seg));
      repeat (125) random_transaction();
    end
    drain();
    // keep the clock running past the drain, to catch any stray result
    repeat (12) @(posedge clk);
    if (board.mismatch_count == 0) begin
      $display("gear_hash_cut_scanner test passed");
    end else begin
      $display("gear_hash_cut_scanner test failed");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("gear_hash_cut_scanner test failed");
    $finish;
  end

endmodule

@@ gear_hash_cut_scanner.f @@
+incdir+hdl
hdl/ghcs_pkg.sv
hdl/ghcs_table_ram.sv
hdl/ghcs_out_fifo.sv
hdl/gear_hash_cut_scanner.sv
tb/ghcs_tb_pkg.sv
tb/tb_top.sv
